/* rtl/nnpe_pkg.sv */
package nnpe_pkg;

   // Byte codes that the transformation cares about.
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_TWO   = 8'h32;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_D     = 8'h44;

   // Mode register codes. The unused fourth code acts as MODE_BOTH.
   localparam logic [1:0] MODE_NORMALIZE = 2'd0;
   localparam logic [1:0] MODE_ESCAPE    = 2'd1;
   localparam logic [1:0] MODE_BOTH      = 2'd2;
   localparam logic [1:0] MODE_RESET     = MODE_BOTH;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      JOB_LITERAL,      // one byte, passed as is
      JOB_ESCAPE,       // %XY for the byte in data
      JOB_NEWLINE,      // CR LF
      JOB_NEWLINE_ESC,  // %0D%0A
      JOB_MARKER        // end marker without a byte
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   data;
      logic         last;
      logic [31:0]  total;
   } job_type;

   // Number of result items a job turns into.
   function automatic logic [2:0] job_len(job_kind_type kind);
      logic [2:0] len;
      unique case (kind)
         JOB_LITERAL:     len = 3'd1;
         JOB_ESCAPE:      len = 3'd3;
         JOB_NEWLINE:     len = 3'd2;
         JOB_NEWLINE_ESC: len = 3'd6;
         JOB_MARKER:      len = 3'd1;
         default:         len = 3'd1;
      endcase
      return len;
   endfunction

   // Number of real output bytes a job adds to the string length.
   function automatic logic [2:0] job_bytes(job_kind_type kind);
      return (kind == JOB_MARKER) ? 3'd0 : job_len(kind);
   endfunction

   // Byte at position idx of the expansion of a job.
   function automatic logic [7:0] job_byte(job_kind_type kind, logic [7:0] data,
                                           logic [2:0] idx);
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] res;
      hi = (data == CHAR_QUOTE) ? CHAR_TWO : CHAR_ZERO;
      lo = (data == CHAR_CR) ? CHAR_D : ((data == CHAR_LF) ? CHAR_A : CHAR_TWO);
      unique case (kind)
         JOB_LITERAL: res = data;
         JOB_ESCAPE: begin
            res = (idx == 3'd0) ? CHAR_PCT : ((idx == 3'd1) ? hi : lo);
         end
         JOB_NEWLINE: res = (idx == 3'd0) ? CHAR_CR : CHAR_LF;
         JOB_NEWLINE_ESC: begin
            if (idx == 3'd0 || idx == 3'd3) begin
               res = CHAR_PCT;
            end else if (idx == 3'd1 || idx == 3'd4) begin
               res = CHAR_ZERO;
            end else if (idx == 3'd2) begin
               res = CHAR_D;
            end else begin
               res = CHAR_A;
            end
         end
         JOB_MARKER: res = 8'h00;
         default:    res = 8'h00;
      endcase
      return res;
   endfunction

endpackage

/* rtl/nnpe_front.sv */
module nnpe_front
   import nnpe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data,
   output logic       push_valid,
   input  logic       push_ready,
   output job_type    push_job
);

   logic [1:0]   mode_ff, mode_in;
   logic         after_cr_ff, after_cr_in;
   logic [31:0]  count_ff, count_in;

   logic         accept;
   logic         norm;
   logic         esc;
   logic         swallow;
   job_kind_type kind;
   logic [32:0]  sum;
   logic [31:0]  sat_count;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && push_ready;
   assign norm       = (mode_ff != MODE_ESCAPE);
   assign esc        = (mode_ff != MODE_NORMALIZE);
   assign swallow    = norm && after_cr_ff && (req_tdata == CHAR_LF);

   always_comb begin
      after_cr_in = 1'b0;
      priority if (swallow) begin
         kind = JOB_MARKER;
      end else if (req_tdata == CHAR_CR) begin
         kind        = norm ? (esc ? JOB_NEWLINE_ESC : JOB_NEWLINE) : JOB_ESCAPE;
         after_cr_in = norm;
      end else if (req_tdata == CHAR_LF) begin
         kind = norm ? (esc ? JOB_NEWLINE_ESC : JOB_NEWLINE) : JOB_ESCAPE;
      end else if (req_tdata == CHAR_QUOTE && esc) begin
         kind = JOB_ESCAPE;
      end else begin
         kind = JOB_LITERAL;
      end
      if (req_tlast) begin
         after_cr_in = 1'b0;
      end
   end

   // Saturating running length of the string.
   assign sum       = {1'b0, count_ff} + {30'd0, job_bytes(kind)};
   assign sat_count = sum[32] ? COUNT_MAX : sum[31:0];
   assign count_in  = req_tlast ? 32'd0 : sat_count;

   assign push_job.kind  = kind;
   assign push_job.data  = req_tdata;
   assign push_job.last  = req_tlast;
   assign push_job.total = sat_count;

   // A swallowed LF in mid string leaves nothing to send.
   assign push_valid = req_tvalid && !(swallow && !req_tlast);

   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_RESET;
         after_cr_ff <= 1'b0;
         count_ff    <= 32'd0;
      end else begin
         mode_ff <= mode_in;
         if (accept) begin
            after_cr_ff <= after_cr_in;
            count_ff    <= count_in;
         end
      end
   end

endmodule

/* rtl/nnpe_queue.sv */
module nnpe_queue
   import nnpe_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(DEPTH);

   job_type             mem [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] fill_ff, fill_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (fill_ff != CntFull);
   assign pop_valid  = (fill_ff != '0);
   assign pop_job    = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* rtl/nnpe_back.sv */
module nnpe_back
   import nnpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  job_type     pop_job,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser
);

   job_type     job_ff;
   logic        job_valid_ff, job_valid_in;
   logic [2:0]  idx_ff, idx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  byte_ff;
   logic        byte_valid_ff;
   logic        run_last_ff;
   logic        string_end_ff;
   logic [31:0] total_ff;

   logic        out_load;
   logic        at_end;
   logic        job_done;
   logic        job_load;

   assign out_load  = !rsp_valid_ff || rsp_tready;
   assign at_end    = (idx_ff == job_len(job_ff.kind) - 3'd1);
   assign job_done  = job_valid_ff && out_load && at_end;
   assign pop_ready = !job_valid_ff || job_done;
   assign job_load  = pop_valid && pop_ready;

   always_comb begin
      job_valid_in = job_valid_ff;
      idx_in       = idx_ff;
      priority if (job_load) begin
         job_valid_in = 1'b1;
         idx_in       = 3'd0;
      end else if (job_done) begin
         job_valid_in = 1'b0;
      end else if (job_valid_ff && out_load) begin
         idx_in = idx_ff + 3'd1;
      end
      rsp_valid_in = out_load ? job_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_load) begin
         job_ff <= pop_job;
      end
      if (out_load) begin
         byte_ff       <= job_byte(job_ff.kind, job_ff.data, idx_ff);
         byte_valid_ff <= (job_ff.kind != JOB_MARKER);
         run_last_ff   <= at_end;
         string_end_ff <= at_end && job_ff.last;
         total_ff      <= (at_end && job_ff.last) ? job_ff.total : 32'd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {total_ff, byte_ff};
   assign rsp_tlast  = run_last_ff;
   assign rsp_tuser  = {string_end_ff, byte_valid_ff};

endmodule

/* rtl/newline_normalize_percent_escape.sv */
// Newline normalizer and percent escaper for one byte string at a time. Each request is one
// source byte, with tlast on the final byte of the string. Mode 0 rewrites every lone CR,
// lone LF or CR LF pair as CR LF; mode 1 escapes CR, LF and double quote as %0D, %0A and
// %22; mode 2 (the reset value, and also what mode 3 does) turns every newline into %0D%0A
// and escapes double quotes. An LF right after a CR is swallowed in the normalizing modes;
// if that LF ends the string, a lone end marker with byte_valid low is sent instead. Each
// response carries one output byte; tlast marks the last response of a source byte, and
// string_end with the saturating byte count of the string marks the last response of the
// string. Requests are taken at one per cycle while the job queue has room, and responses
// leave at one per cycle while the receiver is ready; a source byte expands to one to six
// responses, or none for a swallowed LF inside a string, and the output register and its
// byte sequencer set that rate. A response passes through the job queue, the job register
// and the output register after its request is accepted. The user must write the mode
// through csr_wr_en and csr_wr_data only while no request is in flight; the block itself
// does not enforce this. The mode takes effect on the next request; a change inside a
// string is allowed, and a pending CR carries over into the new mode.
module newline_normalize_percent_escape
   import nnpe_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // in_last
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_byte, [39:8] total_length
   output logic        rsp_tlast,   // run_last
   output logic [1:0]  rsp_tuser,   // [0] byte_valid, [1] string_end
   // Mode register.
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);

   logic    push_valid;
   logic    push_ready;
   job_type push_job;
   logic    pop_valid;
   logic    pop_ready;
   job_type pop_job;

   // The front end classifies each byte and keeps the CR flag and the running length.
   nnpe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_job    (push_job)
   );

   // The queue lets the front keep taking bytes while a long expansion drains.
   nnpe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // The back end steps through each job and drives the registered response.
   nnpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef NO_ASSERTIONS
   // The end of a string is always the end of a source byte's expansion.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tlast)
      else $error("string_end without run_last");

   // Only the end marker of a string may carry no byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tuser[1] && rsp_tlast))
      else $error("empty response that is not an end marker");

   // The length field is zero except on the end of a string.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[1]) |-> (rsp_tdata[39:8] == 32'd0))
      else $error("total_length set away from string end");

   // Nothing is offered right after reset.
   assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("response valid right after reset");
`endif

endmodule

/* dv/tb_newline_normalize_percent_escape.sv */
`timescale 1ns / 1ps

module tb_newline_normalize_percent_escape;
   import nnpe_pkg::*;

   // The mode register is two bits wide, and its fourth code has no name in the package.
   // The block is meant to treat it exactly like MODE_BOTH.
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // The watchdog limit. It leaves a wide margin over a correct run even when every byte
   // expands to six responses and the receiver stalls hard.
   localparam int CYCLE_LIMIT   = 200000;
   // Idle cycles after the last expected response before the mode is touched. A swallowed
   // LF makes no response, so the block could still be busy when the queue runs dry.
   localparam int SETTLE_CYCLES = 12;
   // Length of the long receiver hold-off that backs the block up into its input.
   localparam int HOLD_CYCLES   = 120;
   localparam int PHASE_BYTES   = 36;

   // How the response side paces its tready.
   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PATTERN,
      RX_HOLD
   } rx_style_type;

   // One response byte as the block should present it.
   typedef struct {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        run_last;
      logic        string_end;
      logic [31:0] total_length;
   } out_char_type;

   // Keeps its own copy of the mode and of the per-string state, expands every accepted
   // request into the response bytes it must produce, and checks responses in order.
   class text_checker;
      logic [1:0]   mode;
      bit           after_cr;
      logic [31:0]  emitted_count;
      out_char_type pending_chars[$];
      logic [7:0]   expansion[$];
      int           errors;
      int           requests;
      int           responses;
      int           strings;
      int           markers;
      int           mode_uses[4];

      function new();
         mode          = MODE_RESET;
         after_cr      = 1'b0;
         emitted_count = '0;
         errors        = 0;
         requests      = 0;
         responses     = 0;
         strings       = 0;
         markers       = 0;
         foreach (mode_uses[i]) mode_uses[i] = 0;
      endfunction

      function void push_escape(logic [7:0] hi, logic [7:0] lo);
         expansion = {expansion, CHAR_PCT};
         expansion = {expansion, hi};
         expansion = {expansion, lo};
      endfunction

      function void push_newline(bit esc);
         if (esc) begin
            push_escape(CHAR_ZERO, CHAR_D);
            push_escape(CHAR_ZERO, CHAR_A);
         end else begin
            expansion = {expansion, CHAR_CR};
            expansion = {expansion, CHAR_LF};
         end
      endfunction

      function int pending();
         return pending_chars.size();
      endfunction

      function void note_request(logic [7:0] in_byte, logic in_last);
         logic [1:0]   eff_mode;
         bit           norm;
         bit           esc;
         int           count;
         logic [31:0]  n;
         out_char_type c;
         expansion.delete();
         eff_mode = (mode == MODE_SPARE) ? MODE_BOTH : mode;
         norm = (eff_mode != MODE_ESCAPE);
         esc  = (eff_mode != MODE_NORMALIZE);
         requests++;
         mode_uses[mode]++;

         if (norm && in_byte == CHAR_LF && after_cr) begin
            after_cr = 1'b0;
         end else if (in_byte == CHAR_CR) begin
            if (norm) push_newline(esc);
            else push_escape(CHAR_ZERO, CHAR_D);
            after_cr = norm;
         end else if (in_byte == CHAR_LF) begin
            if (norm) push_newline(esc);
            else push_escape(CHAR_ZERO, CHAR_A);
            after_cr = 1'b0;
         end else if (in_byte == CHAR_QUOTE && esc) begin
            push_escape(CHAR_TWO, CHAR_TWO);
            after_cr = 1'b0;
         end else begin
            expansion = {expansion, in_byte};
            after_cr = 1'b0;
         end

         n = expansion.size();
         if (COUNT_MAX - emitted_count < n) emitted_count = COUNT_MAX;
         else emitted_count = emitted_count + n;

         count = expansion.size();
         if (count == 0 && in_last) begin
            count = 1;
            markers++;
         end
         for (int k = 0; k < count; k++) begin
            c.byte_valid   = (k < expansion.size());
            c.out_byte     = c.byte_valid ? expansion[k] : 8'h00;
            c.run_last     = (k == count - 1);
            c.string_end   = c.run_last && in_last;
            c.total_length = c.string_end ? emitted_count : 32'd0;
            pending_chars = {pending_chars, c};
         end

         if (in_last) begin
            after_cr      = 1'b0;
            emitted_count = '0;
            strings++;
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [7:0] out_byte, logic byte_valid, logic run_last,
                                   logic string_end, logic [31:0] total_length);
         out_char_type want;
         if (pending_chars.size() == 0) begin
            $error("response with nothing pending: out_byte %0h", out_byte);
            errors++;
            return;
         end
         want = pending_chars.pop_front();
         responses++;
         compare_field("out_byte", 32'(want.out_byte), 32'(out_byte));
         compare_field("byte_valid", 32'(want.byte_valid), 32'(byte_valid));
         compare_field("run_last", 32'(want.run_last), 32'(run_last));
         compare_field("string_end", 32'(want.string_end), 32'(string_end));
         compare_field("total_length", want.total_length, total_length);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] in_byte
   logic        req_tlast = 1'b0;    // in_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [7:0] out_byte, [39:8] total_length
   logic        rsp_tlast;           // run_last
   logic [1:0]  rsp_tuser;           // [0] byte_valid, [1] string_end
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = 2'd0;

   text_checker  board = new();
   rx_style_type rx_style = RX_RANDOM;
   bit           bursty = 1'b1;
   int           burst_left = 0;
   int           cycles = 0;

   newline_normalize_percent_escape u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Watchdog. If the run has not wrapped up by the limit, something has hung.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Response side. Every accepted response is checked against the oldest expected byte.
   // The tready pattern is chosen by the stimulus process; in the hold style this process
   // counts out a long stretch with tready low so the block backs up into its input.
   initial begin : receiver
      int  hold_left;
      bit  held;
      int  tick;
      hold_left = 0;
      held      = 1'b0;
      tick      = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            board.check_response(rsp_tdata[7:0], rsp_tuser[0], rsp_tlast, rsp_tuser[1],
                                 rsp_tdata[39:8]);
         end
         tick++;
         if (rx_style != RX_HOLD) held = 1'b0;
         if (rx_style == RX_HOLD && !held) begin
            hold_left = HOLD_CYCLES;
            held      = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_style)
               RX_ALWAYS:  rsp_tready <= 1'b1;
               RX_PATTERN: rsp_tready <= ((tick % 7) < 4);
               default:    rsp_tready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Offers one request and returns once it has been accepted. In bursty mode the sender
   // goes quiet between bursts of random length.
   task automatic offer_byte(input logic [7:0] in_byte, input logic in_last);
      if (bursty) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= in_byte;
      req_tlast  <= in_last;
      do @(posedge clock); while (!req_tready);
      board.note_request(in_byte, in_last);
   endtask

   // Stops sending and waits until every expected response is in, then lets the block
   // settle so that nothing is still in flight when the mode changes.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.mode = value;
   endtask

   // Random bytes lean heavily on CR, LF and double quote so that CR LF pairs, lone
   // newlines and swallowed LFs show up often; the rest covers the full byte range.
   function automatic logic [7:0] pick_byte();
      logic [7:0] value;
      case ($urandom_range(0, 9))
         0, 1:    value = CHAR_CR;
         2, 3:    value = CHAR_LF;
         4:       value = CHAR_QUOTE;
         5:       value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default: value = 8'($urandom_range(0, 255));
      endcase
      return value;
   endfunction

   task automatic send_string(output int sent);
      int len;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++) offer_byte(pick_byte(), i == len - 1);
      sent = len;
   endtask

   initial begin : stimulus
      logic [1:0]   phase_mode [5];
      rx_style_type phase_rx   [5];
      bit           phase_gaps [5];
      int           phase_sent;
      int           sent;

      phase_mode = '{MODE_NORMALIZE, MODE_ESCAPE, MODE_BOTH, MODE_SPARE, MODE_NORMALIZE};
      phase_rx   = '{RX_RANDOM, RX_PATTERN, RX_HOLD, RX_ALWAYS, RX_RANDOM};
      phase_gaps = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
      phase_mode[4] = 2'($urandom_range(0, 3));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, first at the reset mode (normalize then escape): both byte
      // extremes, a quote, a CR LF pair with the LF swallowed, a lone LF, and a string
      // that ends on a swallowed LF so the block must send a bare end marker.
      offer_byte(8'h00, 1'b0);
      offer_byte(8'hFF, 1'b0);
      offer_byte(CHAR_QUOTE, 1'b0);
      offer_byte(CHAR_CR, 1'b0);
      offer_byte(CHAR_LF, 1'b0);
      offer_byte(CHAR_LF, 1'b0);
      offer_byte(CHAR_CR, 1'b0);
      offer_byte(CHAR_LF, 1'b1);
      quiesce();

      // Plain normalization: CR CR LF gives two newlines, quotes pass through, and a
      // string made of a single LF.
      write_mode(MODE_NORMALIZE);
      offer_byte(CHAR_CR, 1'b0);
      offer_byte(CHAR_CR, 1'b0);
      offer_byte(CHAR_LF, 1'b0);
      offer_byte(CHAR_QUOTE, 1'b0);
      offer_byte(CHAR_A, 1'b1);
      offer_byte(CHAR_LF, 1'b1);
      quiesce();

      // Escape only: an LF after a CR is not swallowed here.
      write_mode(MODE_ESCAPE);
      offer_byte(CHAR_CR, 1'b0);
      offer_byte(CHAR_LF, 1'b0);
      offer_byte(CHAR_QUOTE, 1'b0);
      offer_byte(8'h7F, 1'b1);
      quiesce();

      // Mode switched in the middle of a string. The pending CR flag carries over: the
      // escape-only mode ignores it, a normalizing mode swallows the LF.
      write_mode(MODE_NORMALIZE);
      offer_byte(CHAR_CR, 1'b0);
      quiesce();
      write_mode(MODE_ESCAPE);
      offer_byte(CHAR_LF, 1'b1);
      quiesce();
      write_mode(MODE_BOTH);
      offer_byte(CHAR_CR, 1'b0);
      quiesce();
      write_mode(MODE_NORMALIZE);
      offer_byte(CHAR_LF, 1'b1);
      quiesce();

      // The unnamed fourth mode code.
      write_mode(MODE_SPARE);
      offer_byte(CHAR_QUOTE, 1'b0);
      offer_byte(CHAR_LF, 1'b1);
      quiesce();

      // Random strings, one phase per mode setting. Each phase also picks a pacing for
      // both sides; the hold phase sends back to back while the receiver holds off.
      for (int p = 0; p < 5; p++) begin
         write_mode(phase_mode[p]);
         rx_style   = phase_rx[p];
         bursty     = phase_gaps[p];
         burst_left = 0;
         phase_sent = 0;
         while (phase_sent < PHASE_BYTES) begin
            send_string(sent);
            phase_sent += sent;
         end
         quiesce();
         rx_style = RX_RANDOM;
      end

      if (board.pending() != 0) begin
         $error("%0d expected responses never arrived", board.pending());
         board.errors++;
      end

      $display("Sent %0d bytes in %0d strings and checked %0d output bytes, %0d end markers.",
               board.requests, board.strings, board.responses, board.markers);
      $display("Bytes per mode 0/1/2/3: %0d/%0d/%0d/%0d, in %0d cycles.",
               board.mode_uses[0], board.mode_uses[1], board.mode_uses[2],
               board.mode_uses[3], cycles);
      if (board.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
